[design/gcc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcc_pkg
// Shared widths, reset values and controller/datapath handshake types for the
// greedy color-class graph coloring core.
// ----------------------------------------------------------------------------
package gcc_pkg;

  // Fixed field widths of the channels and the configuration register.
  localparam int ROW_IDX_W  = 6;
  localparam int ROW_BITS_W = 64;
  localparam int COLOR_W    = 6;
  localparam int COUNT_W    = 7;

  // Vertex count register value after reset.
  localparam logic [COUNT_W-1:0] VCOUNT_RESET = 7'd64;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_row;    // write the transferred row into the adjacency memory
    logic start;       // latch the vertex count and clear the coloring state
    logic p_step;      // advance the opener search pointer
    logic open;        // open a new class at the search pointer
    logic take_orow;   // capture the opener's adjacency row
    logic cand_read;   // read the candidate's adjacency row
    logic cand_test;   // test the candidate against the class members
    logic j_step;      // advance the candidate pointer
    logic class_done;  // count the finished class
    logic emit_start;  // rewind the result pointer
    logic emit_read;   // read the color of the result vertex
    logic v_step;      // advance the result pointer
  } gcc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic p_end;      // search pointer reached the vertex count
    logic p_colored;  // vertex at the search pointer already has a color
    logic j_end;      // candidate pointer reached the vertex count
    logic j_skip;     // candidate is colored or neighbors the opener
    logic v_last;     // result pointer is on the final vertex
  } gcc_sts_t;

endpackage : gcc_pkg
`default_nettype wire

[design/gcc_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcc_if
// Valid/ready channel interfaces: adjacency rows in, vertex colors out.
// ----------------------------------------------------------------------------
interface gcc_in_if;
  logic        valid;
  logic        ready;
  logic [5:0]  row_index;
  logic [63:0] row_bits;
  logic        last_row;

  modport source (output valid, output row_index, output row_bits, output last_row,
                  input ready);
  modport sink   (input valid, input row_index, input row_bits, input last_row,
                  output ready);
endinterface : gcc_in_if

interface gcc_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] vertex_index;
  logic [5:0] vertex_color;
  logic [6:0] colors_used;
  logic       last_result;

  modport source (output valid, output vertex_index, output vertex_color,
                  output colors_used, output last_result, input ready);
  modport sink   (input valid, input vertex_index, input vertex_color,
                  input colors_used, input last_result, output ready);
endinterface : gcc_out_if
`default_nettype wire

[design/greedy_color_class_graph_coloring_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// greedy_color_class_graph_coloring_core
// Loads an adjacency matrix one row per transfer and colors the graph
// greedily one color class at a time, then reports each vertex's color.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one adjacency row per transfer (row_index, row_bits,
//   last_row). The transfer marked last_row
//   stores its row and starts the coloring; no row is accepted until all
//   results have been sent.
//   cfg_we/cfg_wdata set the vertex count; write it only while idle.
//   Coloring time is set by the shared adjacency read port: per class, the
//   search steps past colored vertices, opening the class reads and captures
//   the opener's row, and each candidate is either skipped or read and then
//   tested against the class members.
//   out_ch then gives one transfer per vertex in ascending order, each a
//   color memory read followed by an offer held until the receiver is ready. A
//   stalled receiver holds the current result unchanged.
//   Reset (rst_n low, synchronous) returns to row loading and sets the vertex
//   count to 64. Memories are not cleared; every used row must be loaded
//   before a coloring.
// ----------------------------------------------------------------------------
module greedy_color_class_graph_coloring_core #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  gcc_in_if.sink                      in_ch,
  gcc_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [gcc_pkg::COUNT_W-1:0] cfg_wdata
);
  import gcc_pkg::*;

  gcc_cmd_t cmd;
  gcc_sts_t sts;

  // Controller.
  gcc_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_last_row (in_ch.last_row),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  // Datapath.
  gcc_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_row_index     (in_ch.row_index),
    .in_row_bits      (in_ch.row_bits),
    .out_vertex_index (out_ch.vertex_index),
    .out_vertex_color (out_ch.vertex_color),
    .out_colors_used  (out_ch.colors_used),
    .out_last_result  (out_ch.last_result)
  );

endmodule : greedy_color_class_graph_coloring_core
`default_nettype wire

[design/gcc_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcc_datapath
// Adjacency and color memories, coloring masks, pointers and the result
// payload registers. Acts only on commands from the controller.
// ----------------------------------------------------------------------------
module gcc_datapath #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  gcc_pkg::gcc_cmd_t                  cmd,
  output gcc_pkg::gcc_sts_t                  sts,
  input  logic                               cfg_we,
  input  logic [gcc_pkg::COUNT_W-1:0]        cfg_wdata,
  input  logic [gcc_pkg::ROW_IDX_W-1:0]      in_row_index,
  input  logic [gcc_pkg::ROW_BITS_W-1:0]     in_row_bits,
  output logic [gcc_pkg::ROW_IDX_W-1:0]      out_vertex_index,
  output logic [gcc_pkg::COLOR_W-1:0]        out_vertex_color,
  output logic [gcc_pkg::COUNT_W-1:0]        out_colors_used,
  output logic                               out_last_result
);
  import gcc_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  // Configuration and coloring state.
  logic [COUNT_W-1:0]      vertex_count_r;
  logic [CW-1:0]           n_r;
  logic [CW-1:0]           p_r;
  logic [CW-1:0]           j_r;
  logic [CW-1:0]           v_r;
  logic [COUNT_W-1:0]      count_r;
  logic [MAX_VERTICES-1:0] colored_r;
  logic [MAX_VERTICES-1:0] members_r;
  logic [MAX_VERTICES-1:0] orow_r;
  logic [MAX_VERTICES-1:0] adj_rdata_r;
  logic [COLOR_W-1:0]      col_rdata_r;

  // Memories.
  logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
  logic [COLOR_W-1:0]      col_mem [MAX_VERTICES];

  logic [CW-1:0]      n_eff;
  logic               row_ok;
  logic [AW-1:0]      p_idx;
  logic [AW-1:0]      j_idx;
  logic [AW-1:0]      v_idx;
  logic               adj_rd_en;
  logic [AW-1:0]      adj_raddr;
  logic               cand_join;
  logic               col_we;
  logic [AW-1:0]      col_waddr;

  assign p_idx = p_r[AW-1:0];
  assign j_idx = j_r[AW-1:0];
  assign v_idx = v_r[AW-1:0];

  // Clamp the configured vertex count to the range from 1 to the built capacity.
  always_comb begin
    if (vertex_count_r == '0) begin
      n_eff = CW'(1);
    end else if (int'(vertex_count_r) > MAX_VERTICES) begin
      n_eff = CW'(MAX_VERTICES);
    end else begin
      n_eff = CW'(vertex_count_r);
    end
  end

  assign row_ok = int'(in_row_index) < MAX_VERTICES;

  // A candidate joins when its row marks none of the current class members.
  assign cand_join = ((adj_rdata_r & members_r) == '0);

  assign adj_rd_en = cmd.open | cmd.cand_read;
  assign adj_raddr = cmd.open ? p_idx : j_idx;
  assign col_we    = cmd.open | (cmd.cand_test & cand_join);
  assign col_waddr = cmd.open ? p_idx : j_idx;

  // Adjacency memory: one write port for row loads, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.load_row && row_ok) begin
      adj_mem[in_row_index[AW-1:0]] <= in_row_bits[MAX_VERTICES-1:0];
    end
    if (adj_rd_en) begin
      adj_rdata_r <= adj_mem[adj_raddr];
    end
  end

  // Color memory: written during coloring, read while results are sent.
  always_ff @(posedge clk) begin
    if (col_we) begin
      col_mem[col_waddr] <= count_r[COLOR_W-1:0];
    end
    if (cmd.emit_read) begin
      col_rdata_r <= col_mem[v_idx];
    end
  end

  // The opener's row is kept for the whole class scan.
  always_ff @(posedge clk) begin
    if (cmd.take_orow) begin
      orow_r <= adj_rdata_r;
    end
  end

  // Pointers, masks and the color counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r <= VCOUNT_RESET;
      n_r            <= '0;
      p_r            <= '0;
      j_r            <= '0;
      v_r            <= '0;
      count_r        <= '0;
      colored_r      <= '0;
      members_r      <= '0;
    end else begin
      if (cfg_we) begin
        vertex_count_r <= cfg_wdata;
      end
      if (cmd.start) begin
        n_r       <= n_eff;
        p_r       <= '0;
        count_r   <= '0;
        colored_r <= '0;
        members_r <= '0;
      end
      if (cmd.p_step) begin
        p_r <= p_r + CW'(1);
      end
      if (cmd.open) begin
        colored_r[p_idx] <= 1'b1;
        members_r        <= '0;
        j_r              <= p_r + CW'(1);
      end
      if (cmd.cand_test && cand_join) begin
        colored_r[j_idx] <= 1'b1;
        members_r[j_idx] <= 1'b1;
      end
      if (cmd.j_step) begin
        j_r <= j_r + CW'(1);
      end
      if (cmd.class_done) begin
        count_r <= count_r + COUNT_W'(1);
      end
      if (cmd.emit_start) begin
        v_r <= '0;
      end
      if (cmd.v_step) begin
        v_r <= v_r + CW'(1);
      end
    end
  end

  // Status to the controller.
  assign sts.p_end     = (p_r == n_r);
  assign sts.p_colored = colored_r[p_idx];
  assign sts.j_end     = (j_r >= n_r);
  assign sts.j_skip    = colored_r[j_idx] | orow_r[j_idx];
  assign sts.v_last    = ((v_r + CW'(1)) == n_r);

  // Result payload.
  assign out_vertex_index = ROW_IDX_W'(v_r);
  assign out_vertex_color = col_rdata_r;
  assign out_colors_used  = count_r;
  assign out_last_result  = sts.v_last;

`ifndef SYNTHESIS
  // Every class member is also marked as colored.
  a_members_colored: assert property (@(posedge clk) disable iff (!rst_n)
    ((members_r & ~colored_r) == '0))
    else $error("class member without a color");

  // Opening a class colors the opener.
  a_open_colors: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.open |=> colored_r[$past(p_idx)])
    else $error("opener not marked as colored");

  // No more colors than the built vertex capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(count_r) <= MAX_VERTICES))
    else $error("color count exceeds capacity");
`endif

endmodule : gcc_datapath
`default_nettype wire

[design/gcc_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcc_ctrl
// Controller state machine: row loading, opener search, class scan and
// result sequencing. Drives the channel handshakes.
// ----------------------------------------------------------------------------
module gcc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last_row,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  gcc_pkg::gcc_sts_t sts,
  output gcc_pkg::gcc_cmd_t cmd
);
  import gcc_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FIND  = 3'd1;
  localparam logic [2:0] S_OROW  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_TEST  = 3'd4;
  localparam logic [2:0] S_EMRD  = 3'd5;
  localparam logic [2:0] S_EMOUT = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // Next state and command decode.
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = (state_r == S_IDLE);
    out_valid = (state_r == S_EMOUT);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_row = 1'b1;
          if (in_last_row) begin
            cmd.start = 1'b1;
            state_nxt = S_FIND;
          end
        end
      end
      S_FIND: begin
        if (sts.p_end) begin
          cmd.emit_start = 1'b1;
          state_nxt      = S_EMRD;
        end else if (sts.p_colored) begin
          cmd.p_step = 1'b1;
        end else begin
          cmd.open  = 1'b1;
          state_nxt = S_OROW;
        end
      end
      S_OROW: begin
        cmd.take_orow = 1'b1;
        state_nxt     = S_SCAN;
      end
      S_SCAN: begin
        if (sts.j_end) begin
          cmd.class_done = 1'b1;
          state_nxt      = S_FIND;
        end else if (sts.j_skip) begin
          cmd.j_step = 1'b1;
        end else begin
          cmd.cand_read = 1'b1;
          state_nxt     = S_TEST;
        end
      end
      S_TEST: begin
        cmd.cand_test = 1'b1;
        cmd.j_step    = 1'b1;
        state_nxt     = S_SCAN;
      end
      S_EMRD: begin
        cmd.emit_read = 1'b1;
        state_nxt     = S_EMOUT;
      end
      S_EMOUT: begin
        if (out_ready) begin
          if (sts.v_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.v_step = 1'b1;
            state_nxt  = S_EMRD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  // Rows are never taken while results are being offered.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input and output active together");

  // A last-row transfer starts the coloring and blocks further rows.
  a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_last_row) |=> !in_ready)
    else $error("rows accepted after the last row");

  // The final result transfer returns the block to row loading.
  a_back_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && sts.v_last) |=> in_ready)
    else $error("not ready after the final result");
`endif

endmodule : gcc_ctrl
`default_nettype wire
